[hw/rtl/layernorm_input_gradient_macros.svh]
// assertion helpers for the layer-norm gradient block
`ifndef LAYERNORM_INPUT_GRADIENT_MACROS_SVH
`define LAYERNORM_INPUT_GRADIENT_MACROS_SVH

`ifndef SYNTHESIS
`define LNG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("layernorm gradient check failed");
`define LNG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("layernorm gradient check failed");
`else
`define LNG_ASSERT(lbl, clk, rst, prop)
`define LNG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/lngrad_pkg.sv]
`default_nettype none
package lngrad_pkg;

  localparam int ROW_LEN  = 64;
  localparam int ROW_LOG  = $clog2(ROW_LEN);
  localparam int IDX_W    = ROW_LOG;

  // one element on its way from the front to the back
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [31:0] gw;
    logic               last;
  } lng_entry_t;

  // divide by 2^k, round to nearest, ties away from zero
  function automatic logic signed [71:0] rdiv_pow2(input logic signed [71:0] a, input int k);
    logic signed [71:0] m;
    logic signed [71:0] q;
    m = (a < 0) ? -a : a;
    q = (m + (72'sd1 <<< (k - 1))) >>> k;
    return (a < 0) ? -q : q;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/lngrad_front.sv]
`default_nettype none
module lngrad_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [47:0]             s_tdata,
  input  wire logic                    q_full,
  output logic                         q_push,
  output lngrad_pkg::lng_entry_t       q_entry
);
  import lngrad_pkg::*;

  logic [IDX_W-1:0] count;
  logic signed [15:0] g_in;
  logic signed [15:0] w_in;

  assign g_in     = s_tdata[31:16];
  assign w_in     = s_tdata[47:32];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.x    = s_tdata[15:0];
    q_entry.gw   = g_in * w_in;
    q_entry.last = (count == IDX_W'(ROW_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= (count == IDX_W'(ROW_LEN - 1)) ? '0 : count + 1'b1;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lngrad_queue.sv]
`default_nettype none
module lngrad_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire lngrad_pkg::lng_entry_t  push_entry,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         empty,
  output lngrad_pkg::lng_entry_t       head
);
  import lngrad_pkg::*;

  lng_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lngrad_back.sv]
`default_nettype none
module lngrad_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [15:0]             epsilon,
  input  wire logic                    q_empty,
  input  wire lngrad_pkg::lng_entry_t  q_head,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [15:0]                  m_tdata,
  output logic                         m_tlast
);
  import lngrad_pkg::*;
  `include "layernorm_input_gradient_macros.svh"

  typedef enum logic [18:0] {
    ST_LOAD  = 19'h00001,
    ST_A_RD  = 19'h00002,
    ST_A_D   = 19'h00004,
    ST_A_SQ  = 19'h00008,
    ST_DIV   = 19'h00010,
    ST_SQRT  = 19'h00020,
    ST_B_RD  = 19'h00040,
    ST_B_D   = 19'h00080,
    ST_B_MUL = 19'h00100,
    ST_B_XH  = 19'h00200,
    ST_B_T2  = 19'h00400,
    ST_B_FIN = 19'h00800,
    ST_C_RD  = 19'h01000,
    ST_C_M1  = 19'h02000,
    ST_C_M2  = 19'h04000,
    ST_C_P   = 19'h08000,
    ST_C_DIF = 19'h10000,
    ST_C_MUL = 19'h20000,
    ST_C_OUT = 19'h40000
  } state_t;

  state_t state;

  logic signed [15:0] x_mem  [ROW_LEN];
  logic signed [31:0] gw_mem [ROW_LEN];
  logic signed [22:0] xh_mem [ROW_LEN];
  logic signed [15:0] x_rd;
  logic signed [31:0] gw_rd;
  logic signed [22:0] xh_rd;

  logic [IDX_W-1:0]   idx;
  logic               idx_last;
  logic signed [21:0] x_sum;
  logic signed [23:0] d_r;
  logic signed [47:0] d_sq;
  logic [51:0]        sum_d2;
  logic [34:0]        w_raw;
  logic [34:0]        w_div;
  logic [5:0]         div_cnt;
  logic [34:0]        rem;
  logic [35:0]        rem_sh;
  logic [55:0]        quo;
  logic [57:0]        sq_v;
  logic [57:0]        sq_res;
  logic [57:0]        sq_bit;
  logic [57:0]        sq_try;
  logic [28:0]        sigma;
  logic signed [53:0] prod_r;
  logic signed [31:0] gw_r;
  logic signed [22:0] xh_r;
  logic signed [22:0] xh_next;
  logic signed [71:0] xh_full;
  logic signed [37:0] t1;
  logic signed [60:0] t2_acc;
  logic signed [44:0] t2;
  logic signed [47:0] pp_lo;
  logic signed [43:0] pp_hi;
  logic signed [51:0] p_r;
  logic signed [71:0] inner_full;
  logic signed [71:0] diff_full;
  logic signed [32:0] diff_r;
  logic signed [62:0] rprod;
  logic signed [71:0] r_full;
  logic [15:0]        r_sat;
  logic               out_free;

  assign idx_last = (idx == IDX_W'(ROW_LEN - 1));
  assign q_pop    = (state == ST_LOAD) && !q_empty;
  assign out_free = !m_tvalid || m_tready;

  assign d_sq   = d_r * d_r;
  assign w_raw  = 35'(sum_d2 >> (3 * ROW_LOG)) + 35'(epsilon);
  assign w_div  = (w_raw == '0) ? 35'd1 : w_raw;
  assign rem_sh = {rem, (div_cnt == 6'd56)};
  assign sq_try = sq_res + sq_bit;

  assign xh_full = rdiv_pow2(72'(prod_r), ROW_LOG + 12);
  always_comb begin
    if (xh_full > 72'sd2097152) xh_next = 23'sd2097152;
    else if (xh_full < -72'sd2097152) xh_next = -23'sd2097152;
    else xh_next = 23'(xh_full);
  end

  assign inner_full = rdiv_pow2(72'(p_r) + 72'(t1), ROW_LOG);
  assign diff_full  = 72'(gw_r) - inner_full;
  assign r_full     = rdiv_pow2(72'(rprod), 28);
  always_comb begin
    if (r_full > 72'sd32767) r_sat = 16'h7fff;
    else if (r_full < -72'sd32768) r_sat = 16'h8000;
    else r_sat = r_full[15:0];
  end

  // row buffers, read data registered
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_mem[idx]  <= q_head.x;
      gw_mem[idx] <= q_head.gw;
    end
    if (state == ST_B_XH) begin
      xh_mem[idx] <= xh_next;
    end
    x_rd  <= x_mem[idx];
    gw_rd <= gw_mem[idx];
    xh_rd <= xh_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      idx      <= '0;
      x_sum    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (!q_empty) begin
            x_sum <= x_sum + 22'(q_head.x);
            idx   <= q_head.last ? '0 : idx + 1'b1;
            if (q_head.last) begin
              sum_d2 <= '0;
              state  <= ST_A_RD;
            end
          end
        end
        ST_A_RD: state <= ST_A_D;
        ST_A_D: begin
          d_r   <= (24'(x_rd) <<< ROW_LOG) - 24'(x_sum);
          state <= ST_A_SQ;
        end
        ST_A_SQ: begin
          sum_d2 <= sum_d2 + 52'($unsigned(d_sq));
          idx    <= idx + 1'b1;
          if (idx_last) begin
            div_cnt <= 6'd56;
            rem     <= '0;
            quo     <= '0;
            state   <= ST_DIV;
          end else begin
            state <= ST_A_RD;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, w_div}) begin
            rem <= 35'(rem_sh - {1'b0, w_div});
            quo <= {quo[54:0], 1'b1};
          end else begin
            rem <= rem_sh[34:0];
            quo <= {quo[54:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            sq_v   <= {1'b0, quo, (rem_sh >= {1'b0, w_div})};
            sq_res <= '0;
            sq_bit <= 58'd1 << 56;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            idx    <= '0;
            t1     <= '0;
            t2_acc <= '0;
            state  <= ST_B_RD;
          end
        end
        ST_B_RD: state <= ST_B_D;
        ST_B_D: begin
          d_r   <= (24'(x_rd) <<< ROW_LOG) - 24'(x_sum);
          gw_r  <= gw_rd;
          state <= ST_B_MUL;
        end
        ST_B_MUL: begin
          prod_r <= d_r * $signed({1'b0, sigma});
          state  <= ST_B_XH;
        end
        ST_B_XH: begin
          xh_r  <= xh_next;
          t1    <= t1 + 38'(gw_r);
          state <= ST_B_T2;
        end
        ST_B_T2: begin
          t2_acc <= t2_acc + 61'(gw_r * xh_r);
          idx    <= idx + 1'b1;
          state  <= idx_last ? ST_B_FIN : ST_B_RD;
        end
        ST_B_FIN: begin
          t2    <= 45'(rdiv_pow2(72'(t2_acc), 16));
          state <= ST_C_RD;
        end
        ST_C_RD: state <= ST_C_M1;
        ST_C_M1: begin
          pp_lo <= 48'(xh_rd * $signed({1'b0, t2[23:0]}));
          xh_r  <= xh_rd;
          gw_r  <= gw_rd;
          state <= ST_C_M2;
        end
        ST_C_M2: begin
          pp_hi <= 44'(xh_r * $signed(t2[44:24]));
          state <= ST_C_P;
        end
        ST_C_P: begin
          p_r   <= 52'(rdiv_pow2((72'(pp_hi) <<< 24) + 72'(pp_lo), 16));
          state <= ST_C_DIF;
        end
        ST_C_DIF: begin
          if (diff_full > 72'sd2147483648) diff_r <= 33'sd2147483648;
          else if (diff_full < -72'sd2147483648) diff_r <= -33'sd2147483648;
          else diff_r <= 33'(diff_full);
          state <= ST_C_MUL;
        end
        ST_C_MUL: begin
          rprod <= 63'(diff_r * $signed({1'b0, sigma}));
          state <= ST_C_OUT;
        end
        ST_C_OUT: begin
          if (out_free) begin
            m_tdata  <= r_sat;
            m_tlast  <= idx_last;
            idx      <= idx + 1'b1;
            if (idx_last) begin
              x_sum <= '0;
              state <= ST_LOAD;
            end else begin
              state <= ST_C_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
      // output beat held until taken
      if (state == ST_C_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sigma = sq_res[28:0];

  `LNG_ASSERT(a_div_nonzero, clk, rst, (state == ST_DIV) |-> (w_div != '0))
  `LNG_ASSERT(a_sigma_nonzero, clk, rst, (state == ST_B_RD) |-> (sigma != '0))
  `LNG_ASSERT(a_out_from_emit, clk, rst, (m_tvalid && !$past(m_tvalid)) |-> ($past(state) == ST_C_OUT))
  `LNG_ASSERT(a_load_only_idle_out, clk, rst, q_pop |=> (state == ST_LOAD || state == ST_A_RD))

endmodule
`default_nettype wire

[hw/rtl/layernorm_input_gradient.sv]
// channel  | dir | tdata fields (low bit up)                         | tlast
// s_*      | in  | x_value[15:0] grad_value[31:16] weight_value[47:32] | -
// m_*      | out | grad_out_value[15:0]                              | last_of_row
// cfg_*    | in  | epsilon[15:0], written when cfg_we is high         | -
//
// a row of 64 beats loads at one beat per cycle while s_tvalid stays high; the
// back then runs the variance pass, a restoring divide, a square root, the t1/t2
// pass and the emit pass, one row at a time
// up to two beats of the next row wait in the queue, then s_tready drops
// synchronous active-high reset; epsilon resets to 1
`default_nettype none
module layernorm_input_gradient (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // x_value, grad_value, weight_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // grad_out_value
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import lngrad_pkg::*;

  // epsilon in variance format (scaled by 2^-24)
  logic [15:0] epsilon;

  // front to queue
  logic       q_push;
  lng_entry_t q_in;
  logic       q_full;
  // queue to back
  logic       q_pop;
  logic       q_empty;
  lng_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 16'd1;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  // front: takes beats, forms g*w, marks the row end
  lngrad_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // two-entry queue decouples intake from the row passes
  lngrad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // back: row buffers, statistics, sigma, emit
  lngrad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .epsilon  (epsilon),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

[tb/tb_layernorm_input_gradient.sv]
`default_nettype none
module tb_layernorm_input_gradient;
  timeunit 1ns;
  timeprecision 1ps;

  import lngrad_pkg::*;

  // one result beat: gradient and end-of-row flag
  typedef struct {
    logic signed [15:0] grad;
    logic               last;
  } grad_beat_t;

  // row predictor plus queue of expected gradients
  class lngrad_scoreboard;
    int signed   x_row[ROW_LEN];
    longint      gw_row[ROW_LEN];
    int          n_loaded;
    longint      x_total;
    int unsigned eps;
    grad_beat_t  pending[$];
    int          n_errors;
    int          n_checked;

    function void clear_row();
      n_loaded = 0;
      x_total  = 0;
    endfunction

    static function longint round_div(longint a, longint b);
      longint m;
      longint q;
      m = (a < 0) ? -a : a;
      q = (m + b / 2) / b;
      return (a < 0) ? -q : q;
    endfunction

    static function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // note one accepted element; a full row produces ROW_LEN expectations
    function void note_element(logic signed [15:0] x, logic signed [15:0] g,
                               logic signed [15:0] w);
      longint          d;
      longint unsigned sum_d2;
      longint unsigned wv;
      longint unsigned sig;
      longint          t1;
      longint          t2;
      longint          xh[ROW_LEN];
      longint          p;
      longint          inner;
      longint          diff;
      longint          r;
      grad_beat_t      e;
      x_row[n_loaded]  = x;
      gw_row[n_loaded] = longint'(g) * longint'(w);
      x_total += x;
      n_loaded++;
      if (n_loaded < ROW_LEN) return;
      sum_d2 = 0;
      for (int i = 0; i < ROW_LEN; i++) begin
        d = longint'(x_row[i]) * ROW_LEN - x_total;
        sum_d2 += longint'(d * d);
      end
      wv = sum_d2 / (ROW_LEN * ROW_LEN * ROW_LEN) + eps;
      if (wv == 0) wv = 1;  // zero variance, zero epsilon
      sig = int_sqrt((64'd1 << 56) / wv);
      t1 = 0;
      t2 = 0;
      for (int i = 0; i < ROW_LEN; i++) begin
        d = longint'(x_row[i]) * ROW_LEN - x_total;
        xh[i] = clip(round_div(d * longint'(sig), ROW_LEN * 4096), 64'sd1 << 21);
        t1 += gw_row[i];
        t2 += gw_row[i] * xh[i];
      end
      t2 = round_div(t2, 65536);
      for (int i = 0; i < ROW_LEN; i++) begin
        p     = round_div(xh[i] * t2, 65536);
        inner = round_div(p + t1, ROW_LEN);
        diff  = clip(gw_row[i] - inner, 64'sd1 << 31);
        r     = round_div(diff * longint'(sig), 64'sd1 << 28);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        e.grad = r[15:0];
        e.last = (i == ROW_LEN - 1);
        pending.push_back(e);
      end
      clear_row();
    endfunction

    function void check_beat(logic [15:0] grad, logic last);
      grad_beat_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result beat grad=%0d last=%0b", $signed(grad), last);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (grad !== e.grad) begin
        $error("grad_out_value expected %0d actual %0d", e.grad, $signed(grad));
        n_errors++;
      end
      if (last !== e.last) begin
        $error("last_of_row expected %0b actual %0b", e.last, last);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // x_value, grad_value, weight_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // grad_out_value
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  localparam longint CYCLE_LIMIT = 2_000_000;

  lngrad_scoreboard sb;
  longint cycles = 0;
  bit     calm = 1'b0;  // when set, neither side idles
  int     rows_sent = 0;

  layernorm_input_gradient dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random backpressure, check each accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  // push one element, with random idle cycles ahead of it unless calm is set
  task automatic send_element(logic [15:0] x, logic [15:0] g, logic [15:0] w);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w, g, x};
    do @(posedge clk); while (!s_tready);
    sb.note_element(x, g, w);
  endtask

  // kinds of row: 0 random, 1 constant x, 2 extremes, 3 small spread
  task automatic send_row(int kind);
    logic [15:0] x;
    logic [15:0] g;
    logic [15:0] w;
    logic [15:0] base;
    base = $urandom;
    for (int i = 0; i < ROW_LEN; i++) begin
      g = $urandom;
      w = $urandom;
      case (kind)
        1: x = base;
        2: begin
          x = (i % 2) ? 16'h7fff : 16'h8000;
          g = (i % 3 == 0) ? 16'h8000 : 16'h7fff;
          w = (i % 4 < 2) ? 16'h8000 : 16'h7fff;
        end
        3: x = base + $urandom_range(7);
        default: x = $urandom;
      endcase
      send_element(x, g, w);
    end
    s_tvalid <= 1'b0;
    rows_sent++;
  endtask

  // wait for every expected beat, then let the back settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.eps = v;
  endtask

  initial begin
    sb = new();
    sb.clear_row();
    sb.eps = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: extremes at the reset epsilon, zero epsilon with zero variance,
    // then the largest epsilon with a small spread
    send_row(2);
    drain();
    write_epsilon(16'h0000);
    send_row(1);
    drain();
    write_epsilon(16'hffff);
    send_row(3);
    drain();

    // random rows across epsilon settings, one stretch without idling
    for (int p = 0; p < 2; p++) begin
      write_epsilon((p == 1) ? 16'h0001 : 16'($urandom));
      calm = (p == 1);
      send_row($urandom_range(9) < 6 ? 0 : $urandom_range(3));
      drain();
    end
    calm = 1'b0;

    $display("rows sent: %0d, result beats checked: %0d, errors: %0d",
             rows_sent, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/lngrad_pkg.sv
hw/rtl/lngrad_front.sv
hw/rtl/lngrad_queue.sv
hw/rtl/lngrad_back.sv
hw/rtl/layernorm_input_gradient.sv
tb/tb_layernorm_input_gradient.sv
